FILE: src/wmvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed median voltage monitor package
// Shared constants, register indexes, level codes and sequencer states.
// ----------------------------------------------------------------------------
package wmvm_pkg;

  // Window depth and derived widths
  localparam int WINDOW   = 8;
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(WINDOW + 1);

  // Payload widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 3;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;
  localparam int M_PAD_W  = M_DATA_W - SAMPLE_W - LEVEL_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVER     = 2'd0,
    CFG_ABSENT   = 2'd1,
    CFG_CRITICAL = 2'd2,
    CFG_LOW      = 2'd3
  } cfg_idx_t;

  // Limit reset values in mV
  localparam logic [SAMPLE_W-1:0] OVER_RST     = 16'd16800;
  localparam logic [SAMPLE_W-1:0] ABSENT_RST   = 16'd1000;
  localparam logic [SAMPLE_W-1:0] CRITICAL_RST = 16'd11200;
  localparam logic [SAMPLE_W-1:0] LOW_RST      = 16'd12000;

  // Status level codes
  typedef enum logic [LEVEL_W-1:0] {
    LVL_OK       = 3'd0,
    LVL_LOW      = 3'd1,
    LVL_CRITICAL = 3'd2,
    LVL_ABSENT   = 3'd3,
    LVL_OVER     = 3'd4
  } level_t;

  // Rank-count sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDC,
    ST_LDC,
    ST_CMP,
    ST_TEST,
    ST_DONE
  } state_t;

endpackage

FILE: src/wmvm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wmvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/windowed_median_voltage_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed median voltage monitor
// Median of the last WINDOW voltage samples with a four-limit status level.
// ----------------------------------------------------------------------------
// Each request carries one sample in mV. The sample is written into an
// 8-entry ring RAM, then a sequencer finds the median by rank counting: for
// each held candidate it reads every held entry through the RAM's single read
// port and one shared comparator counts entries below and not above the
// candidate, stopping at the first candidate whose rank covers count/2. The
// RAM read port and the comparator set the pace of the search. The status
// level is taken from the median as the result is loaded. The result sits in
// an output register, and a new sample is taken only once the previous
// result has been loaded there. The user is to write limits through the cfg
// port only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module windowed_median_voltage_monitor (
  input  logic                             clk,
  input  logic                             rst,
  // Sample input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [wmvm_pkg::S_DATA_W-1:0]    s_tdata,   // [15:0] sample_mv
  // Result output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [wmvm_pkg::M_DATA_W-1:0]    m_tdata,   // [15:0] median_mv, [18:16] level
  // Configuration writes
  input  logic                             cfg_we,
  input  logic [wmvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmvm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W    = wmvm_pkg::IDX_W;
  localparam int CNT_W    = wmvm_pkg::CNT_W;
  localparam int SAMPLE_W = wmvm_pkg::SAMPLE_W;

  // Limit registers
  logic [SAMPLE_W-1:0] over_limit;
  logic [SAMPLE_W-1:0] absent_limit;
  logic [SAMPLE_W-1:0] critical_limit;
  logic [SAMPLE_W-1:0] low_limit;

  // Ring state
  logic [IDX_W-1:0] write_slot, write_slot_next;
  logic [CNT_W-1:0] held_count, held_count_next;

  // Sequencer registers
  wmvm_pkg::state_t state, state_next;
  logic [IDX_W-1:0]    cand_idx, cand_idx_next;
  logic [IDX_W-1:0]    scan_idx, scan_idx_next;
  logic [CNT_W-1:0]    less_cnt, less_cnt_next;
  logic [CNT_W-1:0]    le_cnt, le_cnt_next;
  logic [SAMPLE_W-1:0] cand, cand_next;

  // RAM interface
  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Shared comparator and derived terms
  logic                   cmp_lt, cmp_le;
  logic                   scan_last;
  logic [CNT_W-1:0]       mid_rank;
  logic                   rank_hit;
  logic                   out_load;
  wmvm_pkg::level_t       level;

  wmvm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (wmvm_pkg::WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (s_tdata[SAMPLE_W-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      over_limit     <= wmvm_pkg::OVER_RST;
      absent_limit   <= wmvm_pkg::ABSENT_RST;
      critical_limit <= wmvm_pkg::CRITICAL_RST;
      low_limit      <= wmvm_pkg::LOW_RST;
    end else if (cfg_we) begin
      unique case (wmvm_pkg::cfg_idx_t'(cfg_index))
        wmvm_pkg::CFG_OVER:     over_limit     <= cfg_data[SAMPLE_W-1:0];
        wmvm_pkg::CFG_ABSENT:   absent_limit   <= cfg_data[SAMPLE_W-1:0];
        wmvm_pkg::CFG_CRITICAL: critical_limit <= cfg_data[SAMPLE_W-1:0];
        wmvm_pkg::CFG_LOW:      low_limit      <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared comparator: current RAM entry against the candidate
  assign cmp_lt    = (ram_rdata < cand);
  assign cmp_le    = (ram_rdata <= cand);
  assign scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == held_count);
  assign mid_rank  = held_count >> 1;
  assign rank_hit  = (less_cnt <= mid_rank) && (le_cnt > mid_rank);

  // Status level from the median, first matching test wins
  always_comb begin
    if (cand > over_limit) begin
      level = wmvm_pkg::LVL_OVER;
    end else if (cand < absent_limit) begin
      level = wmvm_pkg::LVL_ABSENT;
    end else if (cand < critical_limit) begin
      level = wmvm_pkg::LVL_CRITICAL;
    end else if (cand < low_limit) begin
      level = wmvm_pkg::LVL_LOW;
    end else begin
      level = wmvm_pkg::LVL_OK;
    end
  end

  // Sequencer next state and controls
  always_comb begin
    state_next      = state;
    write_slot_next = write_slot;
    held_count_next = held_count;
    cand_idx_next   = cand_idx;
    scan_idx_next   = scan_idx;
    less_cnt_next   = less_cnt;
    le_cnt_next     = le_cnt;
    cand_next       = cand;
    ram_we          = 1'b0;
    ram_raddr       = cand_idx;
    s_tready        = 1'b0;
    out_load        = 1'b0;

    unique case (state)
      wmvm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ram_we = 1'b1;
          if (write_slot == IDX_W'(wmvm_pkg::WINDOW - 1)) begin
            write_slot_next = '0;
          end else begin
            write_slot_next = write_slot + IDX_W'(1);
          end
          if (held_count != CNT_W'(wmvm_pkg::WINDOW)) begin
            held_count_next = held_count + CNT_W'(1);
          end
          cand_idx_next = '0;
          state_next    = wmvm_pkg::ST_RDC;
        end
      end
      // Fetch candidate
      wmvm_pkg::ST_RDC: begin
        ram_raddr  = cand_idx;
        state_next = wmvm_pkg::ST_LDC;
      end
      // Latch candidate, start scan at entry 0
      wmvm_pkg::ST_LDC: begin
        cand_next     = ram_rdata;
        ram_raddr     = '0;
        scan_idx_next = '0;
        less_cnt_next = '0;
        le_cnt_next   = '0;
        state_next    = wmvm_pkg::ST_CMP;
      end
      // One held entry per cycle through the comparator
      wmvm_pkg::ST_CMP: begin
        ram_raddr     = scan_idx + IDX_W'(1);
        less_cnt_next = less_cnt + CNT_W'(cmp_lt);
        le_cnt_next   = le_cnt + CNT_W'(cmp_le);
        scan_idx_next = scan_idx + IDX_W'(1);
        if (scan_last) begin
          state_next = wmvm_pkg::ST_TEST;
        end
      end
      // Candidate covers rank count/2: it is the median; else try the next candidate
      wmvm_pkg::ST_TEST: begin
        if (rank_hit) begin
          state_next = wmvm_pkg::ST_DONE;
        end else begin
          cand_idx_next = cand_idx + IDX_W'(1);
          state_next    = wmvm_pkg::ST_RDC;
        end
      end
      wmvm_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = wmvm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wmvm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wmvm_pkg::ST_IDLE;
      write_slot <= '0;
      held_count <= '0;
    end else begin
      state      <= state_next;
      write_slot <= write_slot_next;
      held_count <= held_count_next;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    cand_idx <= cand_idx_next;
    scan_idx <= scan_idx_next;
    less_cnt <= less_cnt_next;
    le_cnt   <= le_cnt_next;
    cand     <= cand_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{wmvm_pkg::M_PAD_W{1'b0}}, level, cand};
    end
  end

`ifndef NO_ASSERTIONS
  // Only one sample in flight: no request taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sample accepted while previous one in progress");

  // Candidate always counts itself, so le exceeds less at the test
  a_rank_sane: assert property (@(posedge clk) disable iff (rst)
    (state == wmvm_pkg::ST_TEST) |-> (le_cnt > less_cnt))
    else $error("rank counts inconsistent");

  // Fill count never passes the window depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(wmvm_pkg::WINDOW))
    else $error("held count over window depth");
`endif

endmodule
